// ===== hdl/crc32_framed_record_checker_macros.svh =====
// Assertion macros used by the record checker top level.
`ifndef CRC32_FRAMED_RECORD_CHECKER_MACROS_SVH
`define CRC32_FRAMED_RECORD_CHECKER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle assertion failed");

`endif

// ===== hdl/crcfrc_pkg.sv =====
// Package with types, constants and the CRC byte update for the record checker.
`timescale 1ns / 1ps

package crcfrc_pkg;

    localparam int MAX_RECORD_BYTES_DEF = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int VERSION_W = 8;
    localparam int LENGTH_W  = 11;
    localparam int CRC_W     = 32;

    localparam logic [CRC_W-1:0]     CRC_POLY = 32'hEDB88320;
    localparam logic [CRC_W-1:0]     CRC_INIT = 32'hFFFFFFFF;

    localparam logic                 MODE_RESET    = 1'b1;
    localparam logic [VERSION_W-1:0] VERSION_RESET = 8'd1;
    localparam logic [LENGTH_W-1:0]  LENGTH_RESET  = 11'd296;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_BAD_LENGTH  = 2'd1,
        STATUS_BAD_VERSION = 2'd2,
        STATUS_BAD_CRC     = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_MODE       = 2'd0,
        CFG_EXPECTED_VERSION = 2'd1,
        CFG_RECORD_LENGTH    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        status_t          status;
        logic [CRC_W-1:0] crc;
    } result_t;

    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                   input logic [7:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
        end
        return c;
    endfunction

endpackage

// ===== hdl/crcfrc_out_buf.sv =====
// Two-entry output buffer that parts the result channel from the byte channel.
`timescale 1ns / 1ps

module crcfrc_out_buf
    import crcfrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

endmodule

// ===== hdl/crc32_framed_record_checker.sv =====
// Top level of the CRC-32 framed record checker.
//
// Bytes of a record enter on the input channel (data_byte, last_byte) under
// in_valid and in_stall, one item per cycle while in_stall is low. Each byte
// updates the CRC, the byte count and, in verify mode, the trailer delay line
// in the cycle it is accepted. An item with last_byte set yields one result
// item (status, crc_value) on the output channel under out_valid and out_stall;
// other items yield none. A last byte's result is registered in the output
// buffer's main entry unless an earlier result waits on a stalled receiver.
// Throughput is one byte per cycle while in_stall is low, set by the byte-wide
// CRC update between the state registers and the output register.
// A two-entry output buffer lets the block accept bytes while a result waits.
// When the receiver stalls and both entries hold results, in_stall rises until
// the receiver takes one; a stall never drops or repeats a result.
// The user writes configuration (cfg_we, cfg_index, cfg_data) only while idle;
// unenforced by the block. Reset loads check_mode = verify, expected_version = 1
// and record_length = 296, clears the record state and empties the output buffer.
`timescale 1ns / 1ps
`include "crc32_framed_record_checker_macros.svh"

module crc32_framed_record_checker
    import crcfrc_pkg::*;
#(
    parameter int MAX_RECORD_BYTES = MAX_RECORD_BYTES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 last_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           status,
    output logic [CRC_W-1:0]     crc_value
);

    localparam int CNT_W = $clog2(MAX_RECORD_BYTES + 2);
    localparam int CMP_W = (CNT_W > LENGTH_W) ? CNT_W : LENGTH_W;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_RECORD_BYTES + 1);

    logic                 mode_reg;
    logic [VERSION_W-1:0] version_reg;
    logic [LENGTH_W-1:0]  length_reg;

    logic [CRC_W-1:0] crc_reg, crc_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CRC_W-1:0] trailer_reg, trailer_next;
    logic             vmatch_reg, vmatch_next;

    logic [CRC_W-1:0] crc_upd, trailer_upd;
    logic [CNT_W-1:0] cnt_upd;
    logic             vmatch_upd;
    logic             accept;
    logic             overflow;
    result_t          result;
    result_t          out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            version_reg <= VERSION_RESET;
            length_reg  <= LENGTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHECK_MODE:       mode_reg    <= cfg_data[0];
                CFG_EXPECTED_VERSION: version_reg <= cfg_data[VERSION_W-1:0];
                CFG_RECORD_LENGTH:    length_reg  <= cfg_data[LENGTH_W-1:0];
                default:              ;
            endcase
        end
    end

    assign accept = in_valid && !in_stall;

    always_comb
    begin
        crc_upd     = crc_reg;
        trailer_upd = trailer_reg;
        vmatch_upd  = vmatch_reg;
        if (mode_reg)
        begin
            if (cnt_reg == '0)
            begin
                vmatch_upd = (data_byte == version_reg);
            end
            if (cnt_reg >= CNT_W'(4))
            begin
                crc_upd = crc_feed(crc_reg, trailer_reg[7:0]);
            end
            trailer_upd = {data_byte, trailer_reg[CRC_W-1:8]};
        end
        else
        begin
            crc_upd = crc_feed(crc_reg, data_byte);
        end
        cnt_upd = (cnt_reg != CNT_SAT) ? cnt_reg + 1'b1 : cnt_reg;

        overflow      = (cnt_upd == CNT_SAT);
        result.crc    = ~crc_upd;
        result.status = STATUS_OK;
        if (mode_reg)
        begin
            if (overflow || cnt_upd < CNT_W'(4) ||
                CMP_W'(cnt_upd) != CMP_W'(length_reg))
            begin
                result.status = STATUS_BAD_LENGTH;
            end
            else if (!vmatch_upd)
            begin
                result.status = STATUS_BAD_VERSION;
            end
            else if (trailer_upd != ~crc_upd)
            begin
                result.status = STATUS_BAD_CRC;
            end
        end
        else if (overflow)
        begin
            result.status = STATUS_BAD_LENGTH;
        end

        crc_next     = crc_reg;
        cnt_next     = cnt_reg;
        trailer_next = trailer_reg;
        vmatch_next  = vmatch_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                crc_next     = CRC_INIT;
                cnt_next     = '0;
                trailer_next = '0;
                vmatch_next  = 1'b0;
            end
            else
            begin
                crc_next     = crc_upd;
                cnt_next     = cnt_upd;
                trailer_next = trailer_upd;
                vmatch_next  = vmatch_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg     <= CRC_INIT;
            cnt_reg     <= '0;
            trailer_reg <= '0;
            vmatch_reg  <= 1'b0;
        end
        else
        begin
            crc_reg     <= crc_next;
            cnt_reg     <= cnt_next;
            trailer_reg <= trailer_next;
            vmatch_reg  <= vmatch_next;
        end
    end

    crcfrc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && last_byte),
        .push_data (result),
        .full      (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign status    = out_data.status;
    assign crc_value = out_data.crc;

    `ASSERT_SAME_CYCLE(a_full_has_head, clk, rst_n, in_stall, out_valid)
    `ASSERT_NEXT_CYCLE(a_last_gives_result, clk, rst_n, accept && last_byte, out_valid)
    `ASSERT_NEXT_CYCLE(a_last_clears_count, clk, rst_n, accept && last_byte, cnt_reg == '0)
    `ASSERT_SAME_CYCLE(a_count_bounded, clk, rst_n, 1'b1, cnt_reg <= CNT_SAT)

endmodule

// ===== sim/tb_crc32_framed_record_checker.sv =====
// Self-checking testbench for the CRC-32 framed record checker, with random records and stalls.
`timescale 1ns / 1ps

module tb_crc32_framed_record_checker;
    import crcfrc_pkg::*;

    localparam int MAX_BYTES   = MAX_RECORD_BYTES_DEF;
    localparam int QUIET_LIMIT = 1000;

    typedef logic [7:0] byte_list_t[$];

    typedef struct packed {
        logic [7:0] value;
        logic       closes;
    } record_byte_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    cfg_idx_t             cfg_index = CFG_CHECK_MODE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [7:0]           data_byte = 8'd0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [1:0]           status;
    logic [CRC_W-1:0]     crc_value;

    record_byte_t         record_bytes[$];
    result_t              verdict_queue[$];
    int                   items_queued = 0;
    int                   fail_count = 0;
    int                   quiet_cycles = 0;
    bit                   byte_taken = 1'b0;
    bit                   sending = 1'b0;
    bit                   idle_on = 1'b1;
    int                   send_gap = 0;
    int                   hold_gap = 0;

    logic                 mode_cfg = MODE_RESET;
    logic [7:0]           version_cfg = VERSION_RESET;
    logic [LENGTH_W-1:0]  length_cfg = LENGTH_RESET;

    logic [CRC_W-1:0]     run_crc = CRC_INIT;
    logic [10:0]          run_count = '0;
    logic [31:0]          run_trailer = '0;
    logic                 run_version_ok = 1'b0;

    crc32_framed_record_checker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .crc_value (crc_value)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] acc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] r;
        r = acc;
        for (int i = 0; i < 8; i++)
        begin
            if (r[0] ^ b[i])
                r = {1'b0, r[31:1]} ^ CRC_POLY;
            else
                r = {1'b0, r[31:1]};
        end
        return r;
    endfunction

    task automatic track_record_byte(input logic [7:0] b, input logic closes);
        result_t    verdict;
        logic [31:0] sum;
        bit          overflow;
        if (mode_cfg)
        begin
            if (run_count == 0)
                run_version_ok = (b == version_cfg);
            if (run_count >= 4)
                run_crc = crc_step(run_crc, run_trailer[7:0]);
            run_trailer = {b, run_trailer[31:8]};
        end
        else
        begin
            run_crc = crc_step(run_crc, b);
        end
        if (run_count <= MAX_BYTES)
            run_count = run_count + 1'b1;
        if (closes)
        begin
            sum = ~run_crc;
            overflow = (run_count > MAX_BYTES);
            verdict.status = STATUS_OK;
            verdict.crc = sum;
            if (mode_cfg)
            begin
                if (overflow || run_count < 4 || run_count != length_cfg)
                    verdict.status = STATUS_BAD_LENGTH;
                else if (!run_version_ok)
                    verdict.status = STATUS_BAD_VERSION;
                else if (run_trailer != sum)
                    verdict.status = STATUS_BAD_CRC;
            end
            else if (overflow)
            begin
                verdict.status = STATUS_BAD_LENGTH;
            end
            verdict_queue.push_back(verdict);
            run_crc = CRC_INIT;
            run_count = '0;
            run_trailer = '0;
            run_version_ok = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin : observe
        result_t due;
        bit      took_byte;
        bit      took_result;
        took_byte = rst_n && in_valid && !in_stall;
        took_result = rst_n && out_valid && !out_stall;
        byte_taken = took_byte;
        if (took_result)
        begin
            if (verdict_queue.size() == 0)
            begin
                $error("result with no expectation: status %0d crc_value %h",
                       status, crc_value);
                fail_count++;
            end
            else
            begin
                due = verdict_queue.pop_front();
                if (status !== due.status)
                begin
                    $error("status: expected %0d, actual %0d", due.status, status);
                    fail_count++;
                end
                if (crc_value !== due.crc)
                begin
                    $error("crc_value: expected %h, actual %h", due.crc, crc_value);
                    fail_count++;
                end
            end
        end
        if (took_byte)
            track_record_byte(data_byte, last_byte);
        if (took_byte || took_result)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge clk)
    begin : drive
        record_byte_t next_byte;
        if (rst_n && (!in_valid || byte_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
                sending = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(0, 6);
                in_valid <= 1'b0;
                sending = 1'b0;
            end
            else if (record_bytes.size() != 0)
            begin
                next_byte = record_bytes.pop_front();
                data_byte <= next_byte.value;
                last_byte <= next_byte.closes;
                in_valid <= 1'b1;
                sending = 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
                sending = 1'b0;
            end
        end
        if (rst_n)
        begin
            if (hold_gap != 0)
            begin
                hold_gap <= hold_gap - 1;
                out_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                hold_gap <= $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drained();
        while (record_bytes.size() != 0 || sending || verdict_queue.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CHECK_MODE:       mode_cfg = value[0];
            CFG_EXPECTED_VERSION: version_cfg = value[7:0];
            CFG_RECORD_LENGTH:    length_cfg = value[LENGTH_W-1:0];
            default:              ;
        endcase
    endtask

    task automatic push_record(input byte_list_t rec, input bit close);
        foreach (rec[i])
            record_bytes.push_back({rec[i], close && (i == rec.size() - 1)});
        items_queued += rec.size();
    endtask

    function automatic byte_list_t noise_record(input int len);
        byte_list_t rec;
        for (int i = 0; i < len; i++)
            rec.push_back(8'($urandom_range(0, 255)));
        return rec;
    endfunction

    function automatic byte_list_t trailer_record(input int len, input logic [7:0] first);
        byte_list_t  rec;
        logic [31:0] acc;
        acc = CRC_INIT;
        for (int i = 0; i < len - 4; i++)
        begin
            rec.push_back(i == 0 ? first : 8'($urandom_range(0, 255)));
            acc = crc_step(acc, rec[i]);
        end
        acc = ~acc;
        for (int i = 0; i < 4; i++)
            rec.push_back(acc[8*i +: 8]);
        return rec;
    endfunction

    function automatic byte_list_t verify_record();
        byte_list_t rec;
        int         len;
        int         pos;
        int         kind;
        kind = $urandom_range(0, 9);
        if (length_cfg >= 5 && length_cfg <= 40)
            len = length_cfg;
        else
            len = $urandom_range(5, 40);
        if (kind <= 5)
        begin
            rec = trailer_record(len, version_cfg);
        end
        else if (kind == 6)
        begin
            rec = trailer_record(len, version_cfg ^ 8'($urandom_range(1, 255)));
        end
        else if (kind == 7)
        begin
            rec = trailer_record(len, version_cfg);
            pos = $urandom_range(1, len - 1);
            rec[pos] = rec[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        else if (kind == 8)
        begin
            case ($urandom_range(0, 2))
                0:       rec = trailer_record(len + $urandom_range(1, 3), version_cfg);
                1:       rec = noise_record($urandom_range(1, 3));
                default: rec = (len > 5) ? trailer_record(len - 1, version_cfg)
                                         : noise_record(4);
            endcase
        end
        else
        begin
            rec = noise_record($urandom_range(1, 40));
        end
        return rec;
    endfunction

    task automatic pick_settings();
        int pick;
        wait_drained();
        write_reg(CFG_CHECK_MODE, 11'($urandom_range(0, 1)));
        pick = $urandom_range(0, 9);
        write_reg(CFG_EXPECTED_VERSION, pick == 0 ? 11'd0 : pick == 1 ? 11'd255
                                                  : 11'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        if (pick <= 1)
            write_reg(CFG_RECORD_LENGTH, 11'd8);
        else if (pick == 2)
            write_reg(CFG_RECORD_LENGTH, 11'($urandom_range(0, 7)));
        else if (pick == 3)
            write_reg(CFG_RECORD_LENGTH, $urandom_range(0, 1) ? 11'd2047
                                                             : 11'($urandom_range(1025, 2047)));
        else
            write_reg(CFG_RECORD_LENGTH, 11'($urandom_range(9, 40)));
    endtask

    task automatic fill_phase(input int budget, input bit allow_cut);
        byte_list_t rec;
        int         start;
        int         keep;
        start = items_queued;
        while (items_queued - start < budget)
        begin
            rec = mode_cfg ? verify_record() : noise_record($urandom_range(1, 40));
            push_record(rec, 1'b1);
        end
        if (allow_cut && $urandom_range(0, 2) == 0)
        begin
            rec = mode_cfg ? verify_record() : noise_record($urandom_range(1, 40));
            keep = $urandom_range(1, rec.size());
            rec = rec[0:keep-1];
            push_record(rec, 1'b0);
        end
    endtask

    initial
    begin
        byte_list_t rec;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Records too short to hold a trailer, under the reset settings.
        rec = {8'hFF};
        push_record(rec, 1'b1);
        rec = {8'h01, 8'h00, 8'hFF};
        push_record(rec, 1'b1);
        wait_drained();

        write_reg(CFG_RECORD_LENGTH, 11'd8);
        write_reg(CFG_EXPECTED_VERSION, 11'd0);
        rec = trailer_record(8, 8'h00);
        push_record(rec, 1'b1);
        rec[7] = rec[7] ^ 8'h80;
        push_record(rec, 1'b1);
        wait_drained();

        write_reg(CFG_CHECK_MODE, 11'd0);
        rec = {8'hFF, 8'h00};
        push_record(rec, 1'b1);

        for (int p = 0; p < 10; p++)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            pick_settings();
            fill_phase(80, p != 9);
        end

        // A record whose byte count saturates at a length that would otherwise match.
        idle_on = 1'b1;
        wait_drained();
        write_reg(CFG_CHECK_MODE, 11'd1);
        write_reg(CFG_EXPECTED_VERSION, 11'($urandom_range(0, 255)));
        write_reg(CFG_RECORD_LENGTH, 11'd1025);
        rec = trailer_record(1026, version_cfg);
        push_record(rec, 1'b1);

        idle_on = 1'b0;
        pick_settings();
        fill_phase(150, 1'b0);

        wait_drained();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
